[hw/rtl/tspc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_pkg: shared types and constants of the pore cell update unit
// Item structs, configuration register map and reset values, lane sizing.
// ----------------------------------------------------------------------------
package tspc_pkg;

  // Field widths
  localparam int STATE_W = 2;
  localparam int WAIT_W  = 10;
  localparam int NB_W    = 40;
  localparam int DRAW_W  = 24;
  localparam int THR_W   = 25;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 3;

  // Parameter defaults and limits
  localparam int NEIGHBOR_COUNT_DEF = 20;
  localparam int DRAW_BITS_DEF      = 24;
  localparam int MAX_NEIGHBORS      = 20;

  // Neighbor codes handled by one lane
  localparam int LANE_SIZE  = 4;
  localparam int LANE_CNT_W = $clog2(LANE_SIZE + 1);

  // Cell state codes
  localparam logic [STATE_W-1:0] ST_EMPTY     = 2'd0;
  localparam logic [STATE_W-1:0] ST_UNCHARGED = 2'd1;
  localparam logic [STATE_W-1:0] ST_CHARGED   = 2'd2;
  localparam logic [STATE_W-1:0] ST_UNUSED    = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAIT_EMPTY     = 3'd0,
    REG_WAIT_UNCHARGED = 3'd1,
    REG_WAIT_CHARGED   = 3'd2,
    REG_THR_E2U_NEAR   = 3'd3,
    REG_THR_E2U_ALONE  = 3'd4,
    REG_THR_U2C        = 3'd5,
    REG_THR_U2E        = 3'd6,
    REG_THR_C2U        = 3'd7
  } cfg_reg_e;

  // Reset values (Q24 thresholds, 2^24 = 1.0)
  localparam logic [THR_W-1:0] THR_E2U_NEAR_RST  = 25'd16777216;
  localparam logic [THR_W-1:0] THR_E2U_ALONE_RST = 25'd3355;
  localparam logic [THR_W-1:0] THR_U2C_RST       = 25'd16777216;
  localparam logic [THR_W-1:0] THR_U2E_RST       = 25'd16609443;
  localparam logic [THR_W-1:0] THR_C2U_RST       = 25'd84;

  typedef struct packed {
    logic [STATE_W-1:0] cell_state;
    logic [WAIT_W-1:0]  wait_count;
    logic [NB_W-1:0]    neighbor_states;
    logic [DRAW_W-1:0]  draw_first;
    logic [DRAW_W-1:0]  draw_second;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic [WAIT_W-1:0]  next_wait;
  } out_item_t;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_empty;
    logic [WAIT_W-1:0] wait_uncharged;
    logic [WAIT_W-1:0] wait_charged;
    logic [THR_W-1:0]  thr_e2u_near;
    logic [THR_W-1:0]  thr_e2u_alone;
    logic [THR_W-1:0]  thr_u2c;
    logic [THR_W-1:0]  thr_u2e;
    logic [THR_W-1:0]  thr_c2u;
  } cfg_t;

  typedef struct packed {
    logic [LANE_CNT_W-1:0] unch;
    logic [LANE_CNT_W-1:0] chg;
  } lane_count_t;

endpackage

[hw/rtl/tspc_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_lane: neighbor counting lane
// Counts uncharged and charged codes among LANE_SIZE neighbor codes.
// ----------------------------------------------------------------------------
module tspc_lane #(
  parameter int LANE_BASE      = 0,
  parameter int NEIGHBOR_COUNT = tspc_pkg::NEIGHBOR_COUNT_DEF
) (
  input  logic [2*tspc_pkg::LANE_SIZE-1:0] codes,
  output tspc_pkg::lane_count_t            count
);
  import tspc_pkg::*;

  // Only neighbor positions below NEIGHBOR_COUNT take part; code 3 is ignored
  always_comb begin
    count = '0;
    for (int j = 0; j < LANE_SIZE; j++) begin
      if (LANE_BASE + j < NEIGHBOR_COUNT) begin
        if (codes[2*j +: 2] == ST_UNCHARGED) begin
          count.unch = count.unch + LANE_CNT_W'(1);
        end else if (codes[2*j +: 2] == ST_CHARGED) begin
          count.chg = count.chg + LANE_CNT_W'(1);
        end
      end
    end
  end

endmodule

[hw/rtl/tspc_rules.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_rules: lane merge and transition rules
// Adds the lane counts, applies wait and threshold rules, forms the result.
// ----------------------------------------------------------------------------
module tspc_rules #(
  parameter int NEIGHBOR_COUNT = tspc_pkg::NEIGHBOR_COUNT_DEF,
  parameter int DRAW_BITS      = tspc_pkg::DRAW_BITS_DEF,
  parameter int NUM_LANES      = (NEIGHBOR_COUNT + tspc_pkg::LANE_SIZE - 1) /
                                 tspc_pkg::LANE_SIZE
) (
  input  tspc_pkg::in_item_t    item,
  input  tspc_pkg::lane_count_t counts [NUM_LANES],
  input  tspc_pkg::cfg_t        cfg,
  output tspc_pkg::out_item_t   result
);
  import tspc_pkg::*;

  localparam int CNT_W = $clog2(NEIGHBOR_COUNT + 1);
  localparam int DW    = (DRAW_BITS < DRAW_W) ? DRAW_BITS : DRAW_W;
  localparam logic [DRAW_W-1:0] DRAW_MASK = DRAW_W'((64'd1 << DW) - 64'd1);

  logic [CNT_W-1:0]   cnt_u;
  logic [CNT_W-1:0]   cnt_c;
  logic [STATE_W-1:0] st;
  logic [STATE_W-1:0] nxt;
  logic [WAIT_W-1:0]  wt;
  logic [WAIT_W:0]    wc_inc;
  logic [THR_W-1:0]   d1;
  logic [THR_W-1:0]   d2;
  logic               near;
  logic               alone;
  logic               crowd;

  // Merge the lane counts
  always_comb begin
    cnt_u = '0;
    cnt_c = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      cnt_u = cnt_u + CNT_W'(counts[l].unch);
      cnt_c = cnt_c + CNT_W'(counts[l].chg);
    end
  end

  // Unused state code reads as empty
  assign st = (item.cell_state == ST_UNUSED) ? ST_EMPTY : item.cell_state;

  // Wait time of the current state
  always_comb begin
    unique case (st)
      ST_UNCHARGED: wt = cfg.wait_uncharged;
      ST_CHARGED:   wt = cfg.wait_charged;
      default:      wt = cfg.wait_empty;
    endcase
  end

  assign d1    = THR_W'(item.draw_first & DRAW_MASK);
  assign d2    = THR_W'(item.draw_second & DRAW_MASK);
  assign near  = (cnt_u >= CNT_W'(1)) || (cnt_c >= CNT_W'(2));
  assign alone = (cnt_u == '0) && (cnt_c == '0);
  assign crowd = (cnt_u >= CNT_W'(3)) || (cnt_c >= CNT_W'(2));

  // Transition rules, once the wait time has passed
  always_comb begin
    nxt = st;
    if (item.wait_count >= wt) begin
      unique case (st)
        ST_UNCHARGED: begin
          if (crowd) begin
            if (d1 < cfg.thr_u2c) nxt = ST_CHARGED;
            else if (d2 < cfg.thr_u2e) nxt = ST_EMPTY;
          end else if (d1 < cfg.thr_u2e) begin
            nxt = ST_EMPTY;
          end
        end
        ST_CHARGED: begin
          // charged goes to empty unless a crowd and a draw below thr_c2u make it uncharged
          if (crowd && (d1 < cfg.thr_c2u)) nxt = ST_UNCHARGED;
          else nxt = ST_EMPTY;
        end
        default: begin
          if (near) begin
            if (d1 < cfg.thr_e2u_near) nxt = ST_UNCHARGED;
          end else if (alone) begin
            if (d1 < cfg.thr_e2u_alone) nxt = ST_UNCHARGED;
          end
        end
      endcase
    end
  end

  // Counter: clear on change, else saturating increment
  assign wc_inc = {1'b0, item.wait_count} + (WAIT_W + 1)'(1);

  always_comb begin
    result.next_state = nxt;
    if (nxt != st) begin
      result.next_wait = '0;
    end else if (wc_inc > {1'b0, wt}) begin
      result.next_wait = wt;
    end else begin
      result.next_wait = wc_inc[WAIT_W-1:0];
    end
  end

endmodule

[hw/rtl/three_state_pore_cell_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_state_pore_cell_update_unit: per-cell update of the pore automaton
// One cell item per clock unless stalled; returns next state and wait counter.
// ----------------------------------------------------------------------------
// The unit accepts one cell item every clock unless the output side is stalled
// with both stages full; a result passes the stage 1 register and then the
// output register. The first stage is a row of counting lanes, four neighbor
// codes per lane, whose counts are registered; the second stage merges the
// lane counts, applies the wait and threshold rules and loads the output
// register. Stalls propagate back one stage at a time, so an item is still
// taken while a finished result waits. Configuration writes take effect at
// the next clock and are meant to be made while no item is in flight.
module three_state_pore_cell_update_unit #(
  parameter int NEIGHBOR_COUNT = tspc_pkg::NEIGHBOR_COUNT_DEF,
  parameter int DRAW_BITS      = tspc_pkg::DRAW_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [tspc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [tspc_pkg::CFG_W-1:0]       wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tspc_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tspc_pkg::out_item_t              out_data
);
  import tspc_pkg::*;

  localparam int NUM_LANES = (NEIGHBOR_COUNT + LANE_SIZE - 1) / LANE_SIZE;

  cfg_t        cfg;
  lane_count_t lane_cnt [NUM_LANES];
  lane_count_t s1_cnt   [NUM_LANES];
  in_item_t    s1_item;
  logic        s1_valid;
  logic        s1_load;
  logic        s2_load;
  out_item_t   result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_empty     <= '0;
      cfg.wait_uncharged <= '0;
      cfg.wait_charged   <= '0;
      cfg.thr_e2u_near   <= THR_E2U_NEAR_RST;
      cfg.thr_e2u_alone  <= THR_E2U_ALONE_RST;
      cfg.thr_u2c        <= THR_U2C_RST;
      cfg.thr_u2e        <= THR_U2E_RST;
      cfg.thr_c2u        <= THR_C2U_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_WAIT_EMPTY:     cfg.wait_empty     <= wr_data[WAIT_W-1:0];
        REG_WAIT_UNCHARGED: cfg.wait_uncharged <= wr_data[WAIT_W-1:0];
        REG_WAIT_CHARGED:   cfg.wait_charged   <= wr_data[WAIT_W-1:0];
        REG_THR_E2U_NEAR:   cfg.thr_e2u_near   <= wr_data[THR_W-1:0];
        REG_THR_E2U_ALONE:  cfg.thr_e2u_alone  <= wr_data[THR_W-1:0];
        REG_THR_U2C:        cfg.thr_u2c        <= wr_data[THR_W-1:0];
        REG_THR_U2E:        cfg.thr_u2e        <= wr_data[THR_W-1:0];
        REG_THR_C2U:        cfg.thr_c2u        <= wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s2_load  = !out_valid || out_ready;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;

  // Counting lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    tspc_lane #(
      .LANE_BASE      (l * LANE_SIZE),
      .NEIGHBOR_COUNT (NEIGHBOR_COUNT)
    ) u_lane (
      .codes (in_data.neighbor_states[2*LANE_SIZE*l +: 2*LANE_SIZE]),
      .count (lane_cnt[l])
    );
  end

  // Stage 1: lane counts and item payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item <= in_data;
      s1_cnt  <= lane_cnt;
    end
  end

  // Merge and rules
  tspc_rules #(
    .NEIGHBOR_COUNT (NEIGHBOR_COUNT),
    .DRAW_BITS      (DRAW_BITS),
    .NUM_LANES      (NUM_LANES)
  ) u_rules (
    .item   (s1_item),
    .counts (s1_cnt),
    .cfg    (cfg),
    .result (result)
  );

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_data <= result;
    end
  end

  // Checks
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.next_state != ST_UNUSED))
    else $error("result carries the unused state code");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_item)))
    else $error("stage 1 item lost under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule
